[hdl/qusm_pkg.sv]
// ----------------------------------------------------------------------------
// qusm_pkg
// Shared types and fixed constants of the quad to unit square mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package qusm_pkg;

  // Number of corner registers and the width of their index.
  localparam int unsigned NUM_CFG_REGS = 8;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Cycles the coefficient derivation needs after a corner write.
  localparam logic [1:0] DERIVE_CYCLES = 2'd3;

  // Quadratic path: Ka and Kb saturate to a 31-bit magnitude.
  localparam int unsigned SAT_BITS = 31;
  localparam logic [SAT_BITS-1:0] SAT_MAX = '1;

  // Square root: 64-bit radicand, 32-bit root.
  localparam int unsigned SQ_BITS   = 64;
  localparam int unsigned ROOT_BITS = 32;

  // Control that travels with each item through an axis pipeline.
  typedef struct packed {
    logic valid;
    logic quad;
    logic sweep;
  } axis_ctl_t;

endpackage

`default_nettype wire

[hdl/qusm_axis.sv]
// ----------------------------------------------------------------------------
// qusm_axis
// One axis of the mapper: two pipelined radix-2 dividers, the discriminant,
// a pipelined integer square root and the final range clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module qusm_axis
  import qusm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 28,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire axis_ctl_t                   ctl_i,
  input  wire logic signed [DATA_BITS-1:0] nr_i,
  input  wire logic signed [DATA_BITS-1:0] ar_i,
  input  wire logic signed [DATA_BITS-1:0] d0_i,
  input  wire logic signed [DATA_BITS-1:0] d1_i,
  input  wire logic signed [DATA_BITS-1:0] d2_i,
  output logic                             valid_o,
  output logic [FRAC_BITS:0]               result_o
);

  localparam int unsigned DW   = DATA_BITS;
  localparam int unsigned MW   = DW + 1;
  localparam int unsigned QW   = MW + FRAC_BITS;
  localparam int unsigned XW   = QW + SAT_BITS;
  localparam int unsigned KW   = SAT_BITS + 1;
  localparam int unsigned RW   = ROOT_BITS + 2;
  localparam int unsigned RESW = ROOT_BITS + 2;

  localparam logic [QW-1:0]          ONE_Q   = QW'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]     ONE_OUT = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [RESW-1:0] ONE_R   = RESW'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Numerators and denominators of both quotients.
  // --------------------------------------------------------------------------
  axis_ctl_t             e1_ctl_q;
  logic signed [DW:0]    num_a_q, den_a_q, num_b_q, den_b_q;
  logic signed [DW:0]    num_a_d, den_a_d, num_b_d, den_b_d;

  always_comb begin
    if (ctl_i.quad) begin
      num_a_d = (DW+1)'(ar_i) - (DW+1)'(d1_i);
      den_a_d = (DW+1)'(d2_i) <<< 1;
    end else begin
      num_a_d = (DW+1)'(nr_i) - (DW+1)'(d0_i);
      den_a_d = (DW+1)'(d1_i) - (DW+1)'(ar_i);
    end
    num_b_d = (DW+1)'(d0_i) - (DW+1)'(nr_i);
    den_b_d = (DW+1)'(d2_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_ctl_q <= '0;
    end else begin
      e1_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_a_q <= num_a_d;
    den_a_q <= den_a_d;
    num_b_q <= num_b_d;
    den_b_q <= den_b_d;
  end

  // --------------------------------------------------------------------------
  // Divider pipelines. Entry 0 holds magnitudes and signs, entry k the state
  // after k quotient bits.
  // --------------------------------------------------------------------------
  axis_ctl_t       dctl_q  [QW+1];
  logic [QW-1:0]   dvd_a_q [QW+1];
  logic [QW-1:0]   dvd_b_q [QW+1];
  logic [MW-1:0]   rem_a_q [QW+1];
  logic [MW-1:0]   rem_b_q [QW+1];
  logic [MW-1:0]   dvs_a_q [QW+1];
  logic [MW-1:0]   dvs_b_q [QW+1];
  logic            sa_q    [QW+1];
  logic            sb_q    [QW+1];
  logic            za_q    [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dctl_q[0] <= '0;
    end else begin
      dctl_q[0] <= e1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_a_q[0] <= {(num_a_q[DW] ? $unsigned(-num_a_q) : $unsigned(num_a_q)),
                   {FRAC_BITS{1'b0}}};
    dvd_b_q[0] <= {(num_b_q[DW] ? $unsigned(-num_b_q) : $unsigned(num_b_q)),
                   {FRAC_BITS{1'b0}}};
    dvs_a_q[0] <= den_a_q[DW] ? $unsigned(-den_a_q) : $unsigned(den_a_q);
    dvs_b_q[0] <= den_b_q[DW] ? $unsigned(-den_b_q) : $unsigned(den_b_q);
    rem_a_q[0] <= '0;
    rem_b_q[0] <= '0;
    sa_q[0]    <= num_a_q[DW] ^ den_a_q[DW];
    sb_q[0]    <= num_b_q[DW] ^ den_b_q[DW];
    za_q[0]    <= (den_a_q == '0);
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [MW:0] t_a, t_b, diff_a, diff_b;
    logic        ge_a, ge_b;

    // One restoring step per stage for each divider.
    always_comb begin
      t_a    = {rem_a_q[k-1], dvd_a_q[k-1][QW-1]};
      t_b    = {rem_b_q[k-1], dvd_b_q[k-1][QW-1]};
      diff_a = t_a - {1'b0, dvs_a_q[k-1]};
      diff_b = t_b - {1'b0, dvs_b_q[k-1]};
      ge_a   = (t_a >= {1'b0, dvs_a_q[k-1]});
      ge_b   = (t_b >= {1'b0, dvs_b_q[k-1]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dctl_q[k] <= '0;
      end else begin
        dctl_q[k] <= dctl_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[k] <= ge_a ? diff_a[MW-1:0] : t_a[MW-1:0];
      rem_b_q[k] <= ge_b ? diff_b[MW-1:0] : t_b[MW-1:0];
      dvd_a_q[k] <= {dvd_a_q[k-1][QW-2:0], ge_a};
      dvd_b_q[k] <= {dvd_b_q[k-1][QW-2:0], ge_b};
      dvs_a_q[k] <= dvs_a_q[k-1];
      dvs_b_q[k] <= dvs_b_q[k-1];
      sa_q[k]    <= sa_q[k-1];
      sb_q[k]    <= sb_q[k-1];
      za_q[k]    <= za_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Linear result, and the saturated Ka and Kb of the quadratic case.
  // --------------------------------------------------------------------------
  logic [QW-1:0]       qa, qb;
  logic [XW-1:0]       qa_x, qb_x;
  logic [SAT_BITS-1:0] mag_a, mag_b;
  logic                lin_ok;
  logic [FRAC_BITS:0]  lin_d;

  axis_ctl_t           k_ctl_q;
  logic signed [KW-1:0] ka_q, kb_q;
  logic [SAT_BITS-1:0] ka_mag_q;
  logic [FRAC_BITS:0]  k_lin_q;

  always_comb begin
    qa     = dvd_a_q[QW];
    qb     = dvd_b_q[QW];
    qa_x   = XW'(qa);
    qb_x   = XW'(qb);
    mag_a  = (qa_x > XW'(SAT_MAX)) ? SAT_MAX : qa_x[SAT_BITS-1:0];
    mag_b  = (qb_x > XW'(SAT_MAX)) ? SAT_MAX : qb_x[SAT_BITS-1:0];
    lin_ok = !za_q[QW] && (!sa_q[QW] || (qa == '0)) && (qa <= ONE_Q);
    lin_d  = lin_ok ? qa[FRAC_BITS:0] : (dctl_q[QW].sweep ? ONE_OUT : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_ctl_q <= '0;
    end else begin
      k_ctl_q <= dctl_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    ka_mag_q <= mag_a;
    ka_q     <= sa_q[QW] ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
    kb_q     <= sb_q[QW] ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
    k_lin_q  <= lin_d;
  end

  // --------------------------------------------------------------------------
  // Ka squared and Kb scaled, then the discriminant, then its magnitude.
  // --------------------------------------------------------------------------
  axis_ctl_t                    s2_ctl_q, s3_ctl_q;
  logic [2*SAT_BITS-1:0]        sq_q;
  logic signed [SQ_BITS-1:0]    kbs_q, disc_q;
  logic signed [KW-1:0]         s2_ka_q, s3_ka_q;
  logic [FRAC_BITS:0]           s2_lin_q, s3_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      s2_ctl_q <= k_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= ka_mag_q * ka_mag_q;
    kbs_q    <= SQ_BITS'(kb_q) <<< FRAC_BITS;
    s2_ka_q  <= ka_q;
    s2_lin_q <= k_lin_q;
    disc_q   <= $signed({{(SQ_BITS-2*SAT_BITS){1'b0}}, sq_q}) - kbs_q;
    s3_ka_q  <= s2_ka_q;
    s3_lin_q <= s2_lin_q;
  end

  // --------------------------------------------------------------------------
  // Square root pipeline, one root bit per stage.
  // --------------------------------------------------------------------------
  axis_ctl_t              rctl_q  [ROOT_BITS+1];
  logic [SQ_BITS-1:0]     rx_q    [ROOT_BITS+1];
  logic [RW-1:0]          rrem_q  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]   root_q  [ROOT_BITS+1];
  logic signed [KW-1:0]   rka_q   [ROOT_BITS+1];
  logic [FRAC_BITS:0]     rlin_q  [ROOT_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rctl_q[0] <= '0;
    end else begin
      rctl_q[0] <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q[0]   <= disc_q[SQ_BITS-1] ? $unsigned(-disc_q) : $unsigned(disc_q);
    rrem_q[0] <= '0;
    root_q[0] <= '0;
    rka_q[0]  <= s3_ka_q;
    rlin_q[0] <= s3_lin_q;
  end

  for (genvar j = 1; j <= ROOT_BITS; j++) begin : g_root
    logic [RW+1:0] t, trial, diff;
    logic          ge;

    always_comb begin
      t     = {rrem_q[j-1], rx_q[j-1][SQ_BITS-1 -: 2]};
      trial = {2'b00, root_q[j-1], 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rctl_q[j] <= '0;
      end else begin
        rctl_q[j] <= rctl_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rrem_q[j] <= ge ? diff[RW-1:0] : t[RW-1:0];
      root_q[j] <= {root_q[j-1][ROOT_BITS-2:0], ge};
      rx_q[j]   <= {rx_q[j-1][SQ_BITS-3:0], 2'b00};
      rka_q[j]  <= rka_q[j-1];
      rlin_q[j] <= rlin_q[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // Ka plus or minus the root, then the range clamp and axis select.
  // --------------------------------------------------------------------------
  logic signed [RESW-1:0] ka_r, root_r, res_d;
  axis_ctl_t              f_ctl_q;
  logic signed [RESW-1:0] res_q;
  logic [FRAC_BITS:0]     f_lin_q;

  always_comb begin
    ka_r   = RESW'(rka_q[ROOT_BITS]);
    root_r = $signed({2'b00, root_q[ROOT_BITS]});
    res_d  = (root_r > ka_r) ? (ka_r + root_r) : (ka_r - root_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_ctl_q <= '0;
      valid_o <= 1'b0;
    end else begin
      f_ctl_q <= rctl_q[ROOT_BITS];
      valid_o <= f_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    f_lin_q <= rlin_q[ROOT_BITS];
    if (!f_ctl_q.quad) begin
      result_o <= f_lin_q;
    end else if ((res_q > ONE_R) || (res_q < 0)) begin
      result_o <= f_ctl_q.sweep ? ONE_OUT : '0;
    end else begin
      result_o <= res_q[FRAC_BITS:0];
    end
  end

endmodule

`default_nettype wire

[hdl/quad_to_unit_square_map_core.sv]
// ----------------------------------------------------------------------------
// quad_to_unit_square_map_core
// Inverse bilinear mapping of a screen point inside a quadrilateral to (u,v)
// in the unit square, in fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Corners are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while no
//   point is in flight. After a write, busy_o stays high while the edge
//   normals and per-axis coefficients are rebuilt.
//   A point transfer happens at each rising edge with start_i high and
//   busy_o low; a new point may be given every cycle while busy_o is low.
//   Each point yields one result: done_o is high for exactly one cycle with
//   coord_u_o and coord_v_o valid. The result passes through the point front
//   end, the one-bit-per-stage dividers, the discriminant and the 32-stage
//   square root.
//   Throughput is one point per cycle while busy_o is low.
//   The receiver cannot stall; results are never held back.
//   Reset clears the corners to zero, which yields zero coefficients, and
//   empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_to_unit_square_map_core
  import qusm_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic                         sweep_xmax_i,
  input  wire logic                         sweep_ymax_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]        cfg_wdata_i,
  output logic                              done_o,
  output logic [FRAC_BITS:0]                coord_u_o,
  output logic [FRAC_BITS:0]                coord_v_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned NW = CW + 2;
  localparam int unsigned DW = 2 * CW + 4;

  // --------------------------------------------------------------------------
  // Corner registers and the settle counter.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] corner_q [NUM_CFG_REGS];
  logic [1:0]           derive_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) begin
        corner_q[i] <= '0;
      end
      derive_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        corner_q[cfg_idx_i] <= cfg_wdata_i;
        derive_cnt_q        <= DERIVE_CYCLES;
      end else if (derive_cnt_q != '0) begin
        derive_cnt_q <= derive_cnt_q - 2'd1;
      end
    end
  end

  assign busy_o = (derive_cnt_q != '0);

  // --------------------------------------------------------------------------
  // Edge vectors and normals. Corner order: 00, 01, 11, 10.
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] pax, pay;
  logic signed [NW-1:0] na_x_q, na_y_q, nb_x_q, nb_y_q, nc_x_q, nc_y_q;
  logic signed [NW-1:0] pb_x_q, pb_y_q, pc_x_q, pc_y_q, pd_x_q, pd_y_q;

  always_comb begin
    pax = NW'(corner_q[0]) - NW'(corner_q[6]) + NW'(corner_q[4]) - NW'(corner_q[2]);
    pay = NW'(corner_q[1]) - NW'(corner_q[7]) + NW'(corner_q[5]) - NW'(corner_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      na_x_q <= '0; na_y_q <= '0;
      nb_x_q <= '0; nb_y_q <= '0;
      nc_x_q <= '0; nc_y_q <= '0;
      pb_x_q <= '0; pb_y_q <= '0;
      pc_x_q <= '0; pc_y_q <= '0;
      pd_x_q <= '0; pd_y_q <= '0;
    end else begin
      na_x_q <= pay;
      na_y_q <= -pax;
      pb_x_q <= NW'(corner_q[6]) - NW'(corner_q[0]);
      pb_y_q <= NW'(corner_q[7]) - NW'(corner_q[1]);
      pc_x_q <= NW'(corner_q[2]) - NW'(corner_q[0]);
      pc_y_q <= NW'(corner_q[3]) - NW'(corner_q[1]);
      nb_x_q <= NW'(corner_q[7]) - NW'(corner_q[1]);
      nb_y_q <= NW'(corner_q[0]) - NW'(corner_q[6]);
      nc_x_q <= NW'(corner_q[3]) - NW'(corner_q[1]);
      nc_y_q <= NW'(corner_q[0]) - NW'(corner_q[2]);
      pd_x_q <= NW'(corner_q[0]);
      pd_y_q <= NW'(corner_q[1]);
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient products, one multiplier each.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] m_nad_x_q, m_nad_y_q, m_u0_x_q, m_u0_y_q, m_u1_x_q, m_u1_y_q;
  logic signed [DW-1:0] m_u2_x_q, m_u2_y_q, m_v0_x_q, m_v0_y_q, m_v1_x_q, m_v1_y_q;
  logic signed [DW-1:0] m_v2_x_q, m_v2_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_nad_x_q <= '0; m_nad_y_q <= '0;
      m_u0_x_q  <= '0; m_u0_y_q  <= '0;
      m_u1_x_q  <= '0; m_u1_y_q  <= '0;
      m_u2_x_q  <= '0; m_u2_y_q  <= '0;
      m_v0_x_q  <= '0; m_v0_y_q  <= '0;
      m_v1_x_q  <= '0; m_v1_y_q  <= '0;
      m_v2_x_q  <= '0; m_v2_y_q  <= '0;
    end else begin
      m_nad_x_q <= DW'(na_x_q) * DW'(pd_x_q);
      m_nad_y_q <= DW'(na_y_q) * DW'(pd_y_q);
      m_u0_x_q  <= DW'(nc_x_q) * DW'(pd_x_q);
      m_u0_y_q  <= DW'(nc_y_q) * DW'(pd_y_q);
      m_u1_x_q  <= DW'(nc_x_q) * DW'(pb_x_q);
      m_u1_y_q  <= DW'(nc_y_q) * DW'(pb_y_q);
      m_u2_x_q  <= DW'(na_x_q) * DW'(pb_x_q);
      m_u2_y_q  <= DW'(na_y_q) * DW'(pb_y_q);
      m_v0_x_q  <= DW'(nb_x_q) * DW'(pd_x_q);
      m_v0_y_q  <= DW'(nb_y_q) * DW'(pd_y_q);
      m_v1_x_q  <= DW'(nb_x_q) * DW'(pc_x_q);
      m_v1_y_q  <= DW'(nb_y_q) * DW'(pc_y_q);
      m_v2_x_q  <= DW'(na_x_q) * DW'(pc_x_q);
      m_v2_y_q  <= DW'(na_y_q) * DW'(pc_y_q);
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis coefficients d0, d1, d2.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] du0_q, du1_q, du2_q, dv0_q, dv1_q, dv2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      du0_q <= '0; du1_q <= '0; du2_q <= '0;
      dv0_q <= '0; dv1_q <= '0; dv2_q <= '0;
    end else begin
      du0_q <= m_u0_x_q + m_u0_y_q;
      du1_q <= m_nad_x_q + m_nad_y_q + m_u1_x_q + m_u1_y_q;
      du2_q <= m_u2_x_q + m_u2_y_q;
      dv0_q <= m_v0_x_q + m_v0_y_q;
      dv1_q <= m_nad_x_q + m_nad_y_q + m_v1_x_q + m_v1_y_q;
      dv2_q <= m_v2_x_q + m_v2_y_q;
    end
  end

  // --------------------------------------------------------------------------
  // Point front end: capture, normal products, dot products.
  // --------------------------------------------------------------------------
  logic                 p0_valid_q, p1_valid_q, p2_valid_q;
  logic                 p0_sx_q, p0_sy_q, p1_sx_q, p1_sy_q, p2_sx_q, p2_sy_q;
  logic signed [CW-1:0] px_q, py_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [DW-1:0] ar_q, br_q, cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p0_valid_q <= start_i && !busy_o;
      p1_valid_q <= p0_valid_q;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= point_x_i;
    py_q    <= point_y_i;
    p0_sx_q <= sweep_xmax_i;
    p0_sy_q <= sweep_ymax_i;
    ax_q    <= DW'(na_x_q) * DW'(px_q);
    ay_q    <= DW'(na_y_q) * DW'(py_q);
    bx_q    <= DW'(nb_x_q) * DW'(px_q);
    by_q    <= DW'(nb_y_q) * DW'(py_q);
    cx_q    <= DW'(nc_x_q) * DW'(px_q);
    cy_q    <= DW'(nc_y_q) * DW'(py_q);
    p1_sx_q <= p0_sx_q;
    p1_sy_q <= p0_sy_q;
    ar_q    <= ax_q + ay_q;
    br_q    <= bx_q + by_q;
    cr_q    <= cx_q + cy_q;
    p2_sx_q <= p1_sx_q;
    p2_sy_q <= p1_sy_q;
  end

  // --------------------------------------------------------------------------
  // Axis pipelines: u uses Nc, v uses Nb.
  // --------------------------------------------------------------------------
  axis_ctl_t u_ctl, v_ctl;
  logic      u_valid, v_valid;

  always_comb begin
    u_ctl.valid = p2_valid_q;
    u_ctl.quad  = (du2_q != '0);
    u_ctl.sweep = p2_sx_q;
    v_ctl.valid = p2_valid_q;
    v_ctl.quad  = (dv2_q != '0);
    v_ctl.sweep = p2_sy_q;
  end

  qusm_axis #(
    .DATA_BITS (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_u (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (u_ctl),
    .nr_i     (cr_q),
    .ar_i     (ar_q),
    .d0_i     (du0_q),
    .d1_i     (du1_q),
    .d2_i     (du2_q),
    .valid_o  (u_valid),
    .result_o (coord_u_o)
  );

  qusm_axis #(
    .DATA_BITS (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_axis_v (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (v_ctl),
    .nr_i     (br_q),
    .ar_i     (ar_q),
    .d0_i     (dv0_q),
    .d1_i     (dv1_q),
    .d2_i     (dv2_q),
    .valid_o  (v_valid),
    .result_o (coord_v_o)
  );

  assign done_o = u_valid && v_valid;

endmodule

`default_nettype wire
